FILE: rtl/eputc_pkg.sv
// Shared types, constants and month-length function for the epoch seconds to UTC date converter.
`default_nettype none

package eputc_pkg;

   // Datapath widths
   localparam int AccW = 17;   // remainder / running day count
   localparam int QuoW = 16;   // dividend shift-in and quotient bits
   localparam int StepW = 4;   // step counter, counts down to zero

   // Divisors and calendar constants
   localparam logic [AccW-1:0] SecPerDay  = 17'd86400;
   localparam logic [AccW-1:0] SecPerHour = 17'd3600;
   localparam logic [AccW-1:0] SecPerMin  = 17'd60;
   localparam logic [AccW-1:0] DaysPerWk  = 17'd7;
   localparam logic [AccW-1:0] DaysLeapYr = 17'd366;
   localparam logic [AccW-1:0] DaysComYr  = 17'd365;
   localparam logic [11:0]     BaseYear   = 12'd1970;
   localparam logic [6:0]      BaseMod100 = 7'd70;
   localparam logic [8:0]      BaseMod400 = 9'd370;
   localparam logic [3:0]      LastMonth  = 4'd11;
   localparam logic [3:0]      February   = 4'd1;

   // Result of one pass through the shared subtract unit
   typedef struct packed {
      logic            ge;     // minuend >= subtrahend
      logic [AccW-1:0] diff;   // difference, valid when ge
   } step_result_type;

   // Payload of one result transaction
   typedef struct packed {
      logic [5:0]  second_of_minute;
      logic [5:0]  minute_of_hour;
      logic [4:0]  hour_of_day;
      logic [2:0]  day_of_week;
      logic [11:0] calendar_year;
      logic [3:0]  month_index;
      logic [4:0]  day_of_month;
   } date_type;

   // Days in month m (0 = January), February follows the leap flag
   function automatic logic [4:0] days_in_month(input logic leap, input logic [3:0] m);
      logic [3:0] k;
      k = (m > 4'd6) ? m - 4'd1 : m;
      if (m == February) begin
         days_in_month = leap ? 5'd29 : 5'd28;
      end else begin
         days_in_month = k[0] ? 5'd30 : 5'd31;
      end
   endfunction

endpackage

`default_nettype wire

FILE: rtl/eputc_channels.sv
// Valid/ready channel interfaces for request and response transactions.
`default_nettype none

interface eputc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface eputc_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  second_of_minute;
   logic [5:0]  minute_of_hour;
   logic [4:0]  hour_of_day;
   logic [2:0]  day_of_week;
   logic [11:0] calendar_year;
   logic [3:0]  month_index;
   logic [4:0]  day_of_month;

   modport source (output valid, output second_of_minute, output minute_of_hour,
                   output hour_of_day, output day_of_week, output calendar_year,
                   output month_index, output day_of_month, input ready);
   modport sink   (input valid, input second_of_minute, input minute_of_hour,
                   input hour_of_day, input day_of_week, input calendar_year,
                   input month_index, input day_of_month, output ready);
endinterface

`default_nettype wire

FILE: rtl/epoch_seconds_to_utc_date.sv
// Top level of the epoch seconds to UTC calendar date converter.
`default_nettype none

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into second, minute,
// hour, weekday (0 Sunday), year, month (0 January) and day of month (from 1). All the
// arithmetic goes through one 18-bit subtract-and-compare unit run by a small sequencer.
// A transaction takes 41 restoring division steps (16 for days, 5 for hours, 6 for minutes,
// 14 for the weekday), then walks the years from 1970, one per cycle, then the months up to
// December, then posts the result once the output register is free and returns to idle,
// where the next request is taken. The request side is ready only while the sequencer
// is idle; a finished result sits in an output register, so a new request is taken while
// the previous response still waits.
module epoch_seconds_to_utc_date
   import eputc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   eputc_req_if.sink    req_chan,
   eputc_rsp_if.source  rsp_chan
);

   // Sequencer states
   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StDay    = 3'd1;
   localparam logic [2:0] StHour   = 3'd2;
   localparam logic [2:0] StMin    = 3'd3;
   localparam logic [2:0] StWday   = 3'd4;
   localparam logic [2:0] StYear   = 3'd5;
   localparam logic [2:0] StMonth  = 3'd6;
   localparam logic [2:0] StFinish = 3'd7;

   logic [2:0]      state_ff, state_in;
   logic [AccW-1:0] acc_ff, acc_in;
   logic [QuoW-1:0] quo_ff, quo_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [15:0]     days_ff, days_in;
   logic [4:0]      hour_ff, hour_in;
   logic [5:0]      min_ff, min_in;
   logic [5:0]      sec_ff, sec_in;
   logic [2:0]      dow_ff, dow_in;
   logic [11:0]     year_ff, year_in;
   logic [6:0]      mod100_ff, mod100_in;
   logic [8:0]      mod400_ff, mod400_in;
   logic [3:0]      month_ff, month_in;
   date_type        out_ff, out_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [AccW:0]   unit_a;
   logic [AccW-1:0] unit_b;
   step_result_type unit_res;
   logic [AccW-1:0] div_acc;
   logic [QuoW-1:0] div_quo;
   logic            leap;
   logic            div_phase;
   logic [15:0]     wsum;

   // Leap rule from the running year residues
   assign leap = (year_ff[1:0] == 2'b00) && ((mod100_ff != 7'd0) || (mod400_ff == 9'd0));

   // Operand select for the shared unit
   assign div_phase = (state_ff == StDay) || (state_ff == StHour) ||
                      (state_ff == StMin) || (state_ff == StWday);
   assign unit_a = div_phase ? {acc_ff, quo_ff[QuoW-1]} : {1'b0, acc_ff};

   always_comb begin
      case (state_ff)
         StDay:   unit_b = SecPerDay;
         StHour:  unit_b = SecPerHour;
         StMin:   unit_b = SecPerMin;
         StWday:  unit_b = DaysPerWk;
         StYear:  unit_b = leap ? DaysLeapYr : DaysComYr;
         StMonth: unit_b = {12'd0, days_in_month(leap, month_ff)};
         default: unit_b = SecPerDay;
      endcase
   end

   eputc_step_unit u_step (
      .minuend    (unit_a),
      .subtrahend (unit_b),
      .result     (unit_res)
   );

   // Restoring division step: keep the difference when it fits, shift in the quotient bit
   assign div_acc = unit_res.ge ? unit_res.diff : unit_a[AccW-1:0];
   assign div_quo = {quo_ff[QuoW-2:0], unit_res.ge};
   assign wsum    = days_ff + 16'd4;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      days_in      = days_ff;
      hour_in      = hour_ff;
      min_in       = min_ff;
      sec_in       = sec_ff;
      dow_in       = dow_ff;
      year_in      = year_ff;
      mod100_in    = mod100_ff;
      mod400_in    = mod400_ff;
      month_in     = month_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         StIdle: begin
            if (req_chan.valid) begin
               acc_in   = {1'b0, req_chan.epoch_seconds[31:16]};
               quo_in   = req_chan.epoch_seconds[15:0];
               step_in  = 4'd15;
               state_in = StDay;
            end
         end
         StDay: begin
            acc_in  = div_acc;
            quo_in  = div_quo;
            step_in = step_ff - 4'd1;
            if (step_ff == '0) begin
               // Day count done; time of day goes on to the hour division
               days_in  = div_quo;
               acc_in   = {5'd0, div_acc[16:5]};
               quo_in   = {div_acc[4:0], 11'd0};
               step_in  = 4'd4;
               state_in = StHour;
            end
         end
         StHour: begin
            acc_in  = div_acc;
            quo_in  = div_quo;
            step_in = step_ff - 4'd1;
            if (step_ff == '0) begin
               hour_in  = div_quo[4:0];
               acc_in   = {11'd0, div_acc[11:6]};
               quo_in   = {div_acc[5:0], 10'd0};
               step_in  = 4'd5;
               state_in = StMin;
            end
         end
         StMin: begin
            acc_in  = div_acc;
            quo_in  = div_quo;
            step_in = step_ff - 4'd1;
            if (step_ff == '0) begin
               // Weekday: (days + 4) mod 7, day zero was a Thursday
               min_in   = div_quo[5:0];
               sec_in   = div_acc[5:0];
               acc_in   = {15'd0, wsum[15:14]};
               quo_in   = {wsum[13:0], 2'd0};
               step_in  = 4'd13;
               state_in = StWday;
            end
         end
         StWday: begin
            acc_in  = div_acc;
            quo_in  = div_quo;
            step_in = step_ff - 4'd1;
            if (step_ff == '0) begin
               dow_in    = div_acc[2:0];
               acc_in    = {1'b0, days_ff};
               year_in   = BaseYear;
               mod100_in = BaseMod100;
               mod400_in = BaseMod400;
               state_in  = StYear;
            end
         end
         StYear: begin
            // Remove one whole year per cycle
            if (unit_res.ge) begin
               acc_in    = unit_res.diff;
               year_in   = year_ff + 12'd1;
               mod100_in = (mod100_ff == 7'd99) ? 7'd0 : mod100_ff + 7'd1;
               mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 9'd1;
            end else begin
               month_in = '0;
               state_in = StMonth;
            end
         end
         StMonth: begin
            // Remove one whole month per cycle, December at the latest
            if (unit_res.ge && (month_ff != LastMonth)) begin
               acc_in   = unit_res.diff;
               month_in = month_ff + 4'd1;
            end else begin
               state_in = StFinish;
            end
         end
         StFinish: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_in.second_of_minute = sec_ff;
               out_in.minute_of_hour   = min_ff;
               out_in.hour_of_day      = hour_ff;
               out_in.day_of_week      = dow_ff;
               out_in.calendar_year    = year_ff;
               out_in.month_index      = month_ff;
               out_in.day_of_month     = acc_ff[4:0] + 5'd1;
               rsp_valid_in            = 1'b1;
               state_in                = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      days_ff   <= days_in;
      hour_ff   <= hour_in;
      min_ff    <= min_in;
      sec_ff    <= sec_in;
      dow_ff    <= dow_in;
      year_ff   <= year_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      month_ff  <= month_in;
      out_ff    <= out_in;
   end

   // Channel outputs
   assign req_chan.ready            = (state_ff == StIdle);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.second_of_minute = out_ff.second_of_minute;
   assign rsp_chan.minute_of_hour   = out_ff.minute_of_hour;
   assign rsp_chan.hour_of_day      = out_ff.hour_of_day;
   assign rsp_chan.day_of_week      = out_ff.day_of_week;
   assign rsp_chan.calendar_year    = out_ff.calendar_year;
   assign rsp_chan.month_index      = out_ff.month_index;
   assign rsp_chan.day_of_month     = out_ff.day_of_month;

endmodule

`default_nettype wire

FILE: rtl/eputc_step_unit.sv
// Shared subtract-and-compare unit used for division steps and calendar walks.
`default_nettype none

module eputc_step_unit
   import eputc_pkg::*;
(
   input  wire logic [AccW:0]   minuend,
   input  wire logic [AccW-1:0] subtrahend,
   output step_result_type      result
);

   logic [AccW+1:0] wide_diff;

   // One extra bit catches the borrow
   assign wide_diff   = {1'b0, minuend} - {2'b00, subtrahend};
   assign result.ge   = ~wide_diff[AccW+1];
   assign result.diff = wide_diff[AccW-1:0];

endmodule

`default_nettype wire

FILE: rtl/eputc_checker.sv
// Port-level checks for the date converter, attached to the top level by bind.
`default_nettype none

module eputc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [5:0]  second_of_minute,
   input wire logic [5:0]  minute_of_hour,
   input wire logic [4:0]  hour_of_day,
   input wire logic [2:0]  day_of_week,
   input wire logic [11:0] calendar_year,
   input wire logic [3:0]  month_index,
   input wire logic [4:0]  day_of_month
);

   // A pending response stays up until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // An accepted request keeps the sequencer busy on the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request side ready right after a transaction");

   // Time-of-day fields stay in range
   a_clock_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (second_of_minute < 6'd60) && (minute_of_hour < 6'd60) &&
                    (hour_of_day < 5'd24) && (day_of_week < 3'd7))
      else $error("time of day field out of range");

   // Date fields stay in range
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (month_index < 4'd12) && (day_of_month != 5'd0) &&
                    (calendar_year >= 12'd1970) && (calendar_year <= 12'd2106))
      else $error("calendar field out of range");

endmodule

bind epoch_seconds_to_utc_date eputc_checker u_eputc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .second_of_minute (rsp_chan.second_of_minute),
   .minute_of_hour   (rsp_chan.minute_of_hour),
   .hour_of_day      (rsp_chan.hour_of_day),
   .day_of_week      (rsp_chan.day_of_week),
   .calendar_year    (rsp_chan.calendar_year),
   .month_index      (rsp_chan.month_index),
   .day_of_month     (rsp_chan.day_of_month)
);

`default_nettype wire

FILE: bench/epoch_seconds_to_utc_date_test.sv
// Self-checking testbench for the epoch seconds to UTC calendar date converter.
module epoch_seconds_to_utc_date_test;
   timeunit 1ns;
   timeprecision 1ps;

   import eputc_pkg::*;

   localparam int unsigned SecondsPerMinute = 60;
   localparam int unsigned SecondsPerHour   = 3600;
   localparam int unsigned SecondsPerDay    = 86400;
   localparam int unsigned EpochYear        = 1970;
   localparam int unsigned LastYear         = 2106;
   localparam int unsigned EpochWeekday     = 4;      // 1970-01-01 was a Thursday
   localparam int unsigned DaysPerWeek      = 7;

   localparam int unsigned ClockHalfPeriod  = 4;
   localparam int unsigned ResetCycles      = 12;
   localparam int unsigned MaxGap           = 5;
   localparam int unsigned HoldCycles       = 600;    // long receiver back-pressure
   localparam int unsigned QuietLimit       = 4000;   // cycles without any transaction
   localparam int unsigned SettleCycles     = 200;    // longest conversion plus margin
   localparam int unsigned RandomItems      = 625;

   typedef enum int unsigned {
      Jan, Feb, Mar, Apr, May, Jun, Jul, Aug, Sep, Oct, Nov, Dec
   } month_e;

   // Gregorian leap rule with the century exceptions
   function automatic bit is_leap_year(int unsigned year);
      return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
   endfunction

   function automatic int unsigned year_length(int unsigned year);
      return is_leap_year(year) ? 366 : 365;
   endfunction

   function automatic int unsigned month_length(bit leap, int unsigned month);
      case (month)
         Feb:                return 28 + leap;
         Apr, Jun, Sep, Nov: return 30;
         default:            return 31;
      endcase
   endfunction

   // Broken-down UTC date for a count of seconds since the epoch
   function automatic date_type utc_date_of(logic [31:0] epoch);
      int unsigned seconds;
      int unsigned days;
      int unsigned year;
      int unsigned month;
      bit          leap;
      date_type    date;
      seconds = epoch;
      days    = seconds / SecondsPerDay;
      date.second_of_minute = 6'(seconds % SecondsPerMinute);
      date.minute_of_hour   = 6'((seconds % SecondsPerHour) / SecondsPerMinute);
      date.hour_of_day      = 5'((seconds % SecondsPerDay) / SecondsPerHour);
      date.day_of_week      = 3'((days + EpochWeekday) % DaysPerWeek);
      // strip whole years, then whole months (December at the latest)
      year = EpochYear;
      while (days >= year_length(year)) begin
         days -= year_length(year);
         year++;
      end
      leap  = is_leap_year(year);
      month = Jan;
      while (month < Dec && days >= month_length(leap, month)) begin
         days -= month_length(leap, month);
         month++;
      end
      date.calendar_year = 12'(year);
      date.month_index   = 4'(month);
      date.day_of_month  = 5'(days + 1);
      return date;
   endfunction

   // Seconds at 00:00:00 on the first day of the given month
   function automatic int unsigned month_start_seconds(int unsigned year, int unsigned month);
      int unsigned days;
      days = 0;
      for (int unsigned y = EpochYear; y < year; y++) days += year_length(y);
      for (int unsigned m = Jan; m < month; m++) days += month_length(is_leap_year(year), m);
      return days * SecondsPerDay;
   endfunction

   // Expected dates in request order, compared against each response
   class date_scoreboard;
      date_type    expected_dates[$];
      int unsigned mismatches = 0;

      function void note_request(logic [31:0] epoch);
         expected_dates.push_back(utc_date_of(epoch));
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(date_type got);
         date_type want;
         if (expected_dates.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
            return;
         end
         want = expected_dates.pop_front();
         compare_field("second_of_minute", want.second_of_minute, got.second_of_minute);
         compare_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
         compare_field("hour_of_day", want.hour_of_day, got.hour_of_day);
         compare_field("day_of_week", want.day_of_week, got.day_of_week);
         compare_field("calendar_year", want.calendar_year, got.calendar_year);
         compare_field("month_index", want.month_index, got.month_index);
         compare_field("day_of_month", want.day_of_month, got.day_of_month);
      endfunction
   endclass

   logic clock;
   logic reset;

   eputc_req_if req_chan ();
   eputc_rsp_if rsp_chan ();

   epoch_seconds_to_utc_date i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   date_scoreboard date_board = new;
   bit             steady_flow;        // no idle cycles on either side
   bit             long_hold_pending;  // receiver starts a long hold-off
   int unsigned    quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #ClockHalfPeriod clock = ~clock;
   end

   // Monitor both channels and watch for a stuck block
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            date_board.check_response(date_type'{
               second_of_minute: rsp_chan.second_of_minute,
               minute_of_hour:   rsp_chan.minute_of_hour,
               hour_of_day:      rsp_chan.hour_of_day,
               day_of_week:      rsp_chan.day_of_week,
               calendar_year:    rsp_chan.calendar_year,
               month_index:      rsp_chan.month_index,
               day_of_month:     rsp_chan.day_of_month});
         end
         if (req_chan.valid && req_chan.ready) begin
            date_board.note_request(req_chan.epoch_seconds);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QuietLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Response side: random ready gaps, one long hold-off on request
   initial begin : response_sink
      int unsigned gap;
      rsp_chan.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (long_hold_pending) begin
            rsp_chan.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            long_hold_pending = 1'b0;
         end
         gap = steady_flow ? 0 : $urandom_range(0, MaxGap);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // Offer one request transaction after a random gap, return once accepted
   task automatic send_epoch(logic [31:0] epoch);
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.epoch_seconds <= epoch;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Stop offering requests until every expected response has arrived
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (date_board.expected_dates.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [31:0] directed_epochs[$] = '{
         32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
         32'd31535999,                  // last second of 1970
         32'd31536000,                  // first second of 1971
         32'd68169600,                  // 1972-02-29, first leap day
         32'd94694399,                  // end of leap year 1972
         32'd951782399, 32'd951782400,  // around 2000-02-29, century divisible by 400
         32'd951868800,                 // 2000-03-01
         32'd978307199,                 // last second of 2000
         32'd4102444799,                // last second of 2099
         32'd4107542399, 32'd4107542400, // 2100 is not leap: Feb 28 into Mar 1
         32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
         32'd4291747200,                // 2106-01-01
         32'hFFFF_FFFE, 32'hFFFF_FFFF   // largest input, 2106-02-07 06:28:15
      };
      logic [31:0] epoch;
      int unsigned pick;
      int unsigned year;
      int unsigned month;

      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.epoch_seconds = '0;
      steady_flow            = 1'b0;
      long_hold_pending      = 1'b0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      foreach (directed_epochs[i]) send_epoch(directed_epochs[i]);

      // random: wide values, year and month boundaries, fast early years, top of range
      for (int n = 0; n < RandomItems; n++) begin
         if (n % 50 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         if (n == 200) begin
            steady_flow       = 1'b1;
            long_hold_pending = 1'b1;
         end
         if (n == 400) drain_results();
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            epoch = $urandom();
         end else if (pick < 70) begin
            year  = $urandom_range(EpochYear + 1, LastYear);
            epoch = month_start_seconds(year, Jan) + $urandom_range(0, 2 * SecondsPerDay)
                    - SecondsPerDay;
         end else if (pick < 85) begin
            year  = $urandom_range(EpochYear, LastYear - 1);
            month = $urandom_range(Feb, Dec);
            epoch = month_start_seconds(year, month) + $urandom_range(0, 2 * SecondsPerDay)
                    - SecondsPerDay;
         end else if (pick < 95) begin
            epoch = $urandom_range(0, 3 * 365 * SecondsPerDay);
         end else begin
            epoch = 32'hFFFF_FFFF - $urandom_range(0, 40_000_000);
         end
         send_epoch(epoch);
      end

      drain_results();
      repeat (SettleCycles) @(posedge clock);
      if (date_board.mismatches == 0 && date_board.expected_dates.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
